>>> rtl/core/cbf_pkg.sv
// Package for the closable bounded FIFO.
// Holds command and status codes, register map constants and the result struct.
// No dependencies.
package cbf_pkg;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic             REG_IDX_DEPTH = 1'b0;
  localparam logic [CFG_W-1:0] DEPTH_RESET   = 5'd16;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_CLOSED  = 2'd2
  } status_e;

  typedef struct packed {
    logic    valid;
    status_e status;
    logic    rd_ok;
    logic    can_send;
    logic    can_recv;
  } res_t;

endpackage

>>> rtl/core/cbf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module cbf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cbf_ctrl.sv
// Pointer, close-flag and status logic of the closable bounded FIFO.
// Depends on cbf_pkg. Drives the slot RAM addresses and the registered result.
module cbf_ctrl
  import cbf_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       command_i,
  input  logic             close_send_i,
  input  logic             close_recv_i,
  input  logic [CFG_W-1:0] depth_i,
  input  logic             clear_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  output res_t             res_o
);

  localparam int unsigned PW = $clog2(DEPTH) + 1;

  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic          send_closed_q, send_closed_d;
  logic          recv_closed_q, recv_closed_d;
  res_t          res_q, res_d;

  logic [31:0]   depth_ext;
  logic [PW-1:0] d_eff;
  logic [PW:0]   two_d;
  logic          full, empty;

  function automatic logic [PW:0] fill_of(logic [PW-1:0] w, logic [PW-1:0] r,
                                          logic [PW:0] td);
    logic [PW:0] we_x, re_x;
    we_x = {1'b0, w};
    re_x = {1'b0, r};
    if (we_x >= re_x) begin
      return we_x - re_x;
    end
    return we_x + td - re_x;
  endfunction

  function automatic logic [PW-1:0] advance(logic [PW-1:0] p, logic [PW:0] td);
    logic [PW:0] nx;
    nx = {1'b0, p} + {{PW{1'b0}}, 1'b1};
    if (nx >= td) begin
      return '0;
    end
    return nx[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_of(logic [PW-1:0] p, logic [PW-1:0] d);
    logic [PW-1:0] s;
    s = (p >= d) ? p - d : p;
    return s[AW-1:0];
  endfunction

  always_comb begin
    depth_ext = 32'(depth_i);
    if (depth_i == '0) begin
      d_eff = PW'(1);
    end else if (depth_ext > DEPTH) begin
      d_eff = PW'(DEPTH);
    end else begin
      d_eff = PW'(depth_ext);
    end
    two_d = {d_eff, 1'b0};
    full  = fill_of(wp_q, rp_q, two_d) >= {1'b0, d_eff};
    empty = (wp_q == rp_q);
  end

  assign waddr_o = slot_of(wp_q, d_eff);
  assign raddr_o = slot_of(rp_q, d_eff);

  always_comb begin
    wp_d          = wp_q;
    rp_d          = rp_q;
    send_closed_d = send_closed_q;
    recv_closed_d = recv_closed_q;
    we_o          = 1'b0;
    re_o          = 1'b0;
    res_d         = '0;
    res_d.status  = ST_DONE;
    res_d.valid   = accept_i;
    if (accept_i) begin
      case (cmd_e'(command_i))
        CMD_SEND: begin
          if (send_closed_q) begin
            res_d.status = ST_CLOSED;
          end else if (full) begin
            res_d.status = ST_BLOCKED;
          end else begin
            we_o = 1'b1;
            wp_d = advance(wp_q, two_d);
          end
        end
        CMD_RECV, CMD_PEEK: begin
          if (recv_closed_q) begin
            res_d.status = ST_CLOSED;
          end else if (empty) begin
            res_d.status = ST_BLOCKED;
          end else begin
            re_o        = 1'b1;
            res_d.rd_ok = 1'b1;
            if (cmd_e'(command_i) == CMD_RECV) begin
              rp_d = advance(rp_q, two_d);
            end
          end
        end
        CMD_CLOSE: begin
          send_closed_d = send_closed_q | close_send_i;
          recv_closed_d = recv_closed_q | close_recv_i;
        end
        default: begin
          res_d.status = ST_DONE;
        end
      endcase
    end
    res_d.can_send = !send_closed_d && (fill_of(wp_d, rp_d, two_d) < {1'b0, d_eff});
    res_d.can_recv = !recv_closed_d && (wp_d != rp_d);
    if (clear_i) begin
      wp_d = '0;
      rp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q          <= '0;
      rp_q          <= '0;
      send_closed_q <= 1'b0;
      recv_closed_q <= 1'b0;
      res_q         <= '0;
    end else begin
      wp_q          <= wp_d;
      rp_q          <= rp_d;
      send_closed_q <= send_closed_d;
      recv_closed_q <= recv_closed_d;
      res_q         <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/closable_bounded_fifo.sv
// Top level of the closable bounded FIFO: configuration port, slot RAM and control.
// Depends on cbf_pkg, cbf_ram and cbf_ctrl.
//
// A command is taken at a rising clock edge where start is high and busy is low.
// busy stays low, so one command can be issued in every cycle. Commands are send,
// receive, peek and close, with data_in_i used by send and the close bits by close.
// Each command gives exactly one result, shown on the result ports for one cycle
// with result_valid_o high, in the cycle right after the command was taken. The
// result is registered in the control, and the slot RAM has a registered read port,
// which is read in the command cycle and feeds data_out_o, zero unless the read succeeded.
// Throughput is one command per cycle; the receiver cannot stall the results.
// The APB-style port holds depth_in_use at address 0. Writing it empties the
// queue and keeps the close flags. It should only be written while no command is
// in flight. Reset gives an empty queue with both sides open and a depth of 16.
// Closing a side is sticky until reset.
module closable_bounded_fifo
  import cbf_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  input  logic                  close_send_i,
  input  logic                  close_recv_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [DATA_WIDTH-1:0] data_out_o,
  output logic                  can_send_o,
  output logic                  can_recv_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]      depth_q;
  logic                  cfg_we;
  logic                  accept;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;
  res_t                  res;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_we) begin
      depth_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_DEPTH) ? PDATA_W'(depth_q) : '0;

  cbf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .close_send_i (close_send_i),
    .close_recv_i (close_recv_i),
    .depth_i      (depth_q),
    .clear_i      (cfg_we),
    .we_o         (we),
    .waddr_o      (waddr),
    .re_o         (re),
    .raddr_o      (raddr),
    .res_o        (res)
  );

  cbf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_in_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign result_valid_o = res.valid;
  assign status_o       = res.status;
  assign can_send_o     = res.can_send;
  assign can_recv_o     = res.can_recv;
  assign data_out_o     = res.rd_ok ? rdata : '0;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("A taken command did not give a result in the next cycle.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("A result appeared without a command.");

  a_data_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && data_out_o != '0) |-> (status_o == ST_DONE))
    else $error("Nonzero data on a failed command.");

  a_close_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_CLOSE && close_send_i) |=> !can_send_o)
    else $error("Sending still reported open after a close.");

endmodule

>>> tb/tb_closable_bounded_fifo.sv
`timescale 1ns / 1ps
// Self-checking testbench for closable_bounded_fifo: random and directed commands,
// checked against a behavioral model of the queue. Depends on cbf_pkg and the RTL.
module tb_closable_bounded_fifo;
  import cbf_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] data;
    logic        close_send;
    logic        close_recv;
  } fifo_op_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] data;
    logic        can_send;
    logic        can_recv;
  } fifo_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command_i = CMD_SEND;
  logic [31:0]        data_in_i = '0;
  logic               close_send_i = 1'b0;
  logic               close_recv_i = 1'b0;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic [31:0]        data_out_o;
  logic               can_send_o;
  logic               can_recv_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fifo_op_t     op_queue[$];
  fifo_result_t predicted_results[$];
  int           idle_pct = 34;
  int           items_issued = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  logic         took_item = 1'b0;

  logic [31:0]  slot_words[SLOTS];
  int           wr_ptr = 0;
  int           rd_ptr = 0;
  logic         send_shut = 1'b0;
  logic         recv_shut = 1'b0;
  logic [4:0]   depth_cfg = DEPTH_RESET;

  closable_bounded_fifo dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .data_in_i, .close_send_i,
    .close_recv_i, .result_valid_o, .status_o, .data_out_o, .can_send_o,
    .can_recv_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  function automatic fifo_result_t apply_fifo_op(cmd_e c, logic [31:0] din, logic cs,
                                                 logic cr);
    int d;
    int fill;
    fifo_result_t r;
    d = (depth_cfg == 0) ? 1 : ((depth_cfg > SLOTS) ? SLOTS : int'(depth_cfg));
    fill = (wr_ptr + 2 * d - rd_ptr) % (2 * d);
    r.status = ST_DONE;
    r.data = '0;
    case (c)
      CMD_SEND: begin
        if (send_shut) begin
          r.status = ST_CLOSED;
        end else if (fill >= d) begin
          r.status = ST_BLOCKED;
        end else begin
          slot_words[(wr_ptr >= d) ? wr_ptr - d : wr_ptr] = din;
          wr_ptr = (wr_ptr + 1 == 2 * d) ? 0 : wr_ptr + 1;
        end
      end
      CMD_RECV, CMD_PEEK: begin
        if (recv_shut) begin
          r.status = ST_CLOSED;
        end else if (fill == 0) begin
          r.status = ST_BLOCKED;
        end else begin
          r.data = slot_words[(rd_ptr >= d) ? rd_ptr - d : rd_ptr];
          if (c == CMD_RECV) rd_ptr = (rd_ptr + 1 == 2 * d) ? 0 : rd_ptr + 1;
        end
      end
      default: begin
        if (cs) send_shut = 1'b1;
        if (cr) recv_shut = 1'b1;
      end
    endcase
    fill = (wr_ptr + 2 * d - rd_ptr) % (2 * d);
    r.can_send = !send_shut && fill < d;
    r.can_recv = !recv_shut && fill != 0;
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    fifo_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        exp_r = predicted_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          mismatches++;
        end
        if (data_out_o !== exp_r.data) begin
          $error("data_out: expected %h, got %h", exp_r.data, data_out_o);
          mismatches++;
        end
        if (can_send_o !== exp_r.can_send) begin
          $error("can_send: expected %0d, got %0d", exp_r.can_send, can_send_o);
          mismatches++;
        end
        if (can_recv_o !== exp_r.can_recv) begin
          $error("can_recv: expected %0d, got %0d", exp_r.can_recv, can_recv_o);
          mismatches++;
        end
      end
    end
    took_item <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      predicted_results.push_back(apply_fifo_op(cmd_e'(command_i), data_in_i,
                                                close_send_i, close_recv_i));
    end
  end

  always @(negedge clk_i) begin : driver
    fifo_op_t op;
    if (rst_ni && (!start || took_item)) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = op_queue.pop_front();
        command_i    <= op.cmd;
        data_in_i    <= op.data;
        close_send_i <= op.close_send;
        close_recv_i <= op.close_recv;
        start        <= 1'b1;
        items_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_op(cmd_e c, logic [31:0] din = '0, logic cs = 1'b0,
                        logic cr = 1'b0);
    fifo_op_t op;
    op.cmd = c;
    op.data = din;
    op.close_send = cs;
    op.close_recv = cr;
    op_queue.push_back(op);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (op_queue.size() != 0 || items_issued != results_seen);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_depth(logic [4:0] value);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    depth_cfg = value;
    wr_ptr = 0;
    rd_ptr = 0;
  endtask

  task automatic add_random_ops(int count, bit allow_close);
    int send_bias;
    int pick;
    logic [31:0] word;
    send_bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) send_bias = $urandom_range(85, 15);
      pick = $urandom_range(99);
      if (pick < 3) begin
        add_op(CMD_CLOSE, $urandom, allow_close && $urandom_range(19) == 0,
               allow_close && $urandom_range(39) == 0);
      end else if ($urandom_range(99) < send_bias) begin
        case ($urandom_range(9))
          0: word = '0;
          1: word = '1;
          default: word = $urandom;
        endcase
        add_op(CMD_SEND, word);
      end else begin
        add_op(($urandom_range(2) != 0) ? CMD_RECV : CMD_PEEK);
      end
    end
  endtask

  initial begin
    int depth_plan[12];
    depth_plan = '{1, 2, 3, 16, 5, 0, 7, 31, 4, 16, 9, 17};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_op(CMD_PEEK);
    add_op(CMD_RECV);
    add_op(CMD_SEND, 32'h0000_0000);
    add_op(CMD_SEND, 32'hFFFF_FFFF);
    add_op(CMD_SEND, 32'hAAAA_AAAA);
    add_op(CMD_SEND, 32'h5555_5555);
    add_op(CMD_PEEK);
    add_op(CMD_RECV);
    add_op(CMD_RECV);
    add_op(CMD_CLOSE);
    add_op(CMD_RECV);
    add_op(CMD_RECV);
    add_op(CMD_RECV);

    write_depth(5'd0);
    add_op(CMD_SEND, 32'h8000_0001);
    add_op(CMD_SEND, 32'h1234_5678);
    add_op(CMD_PEEK);
    add_op(CMD_RECV);
    add_op(CMD_RECV);
    add_op(CMD_SEND, 32'h7FFF_FFFE);
    add_op(CMD_SEND, 32'h0F0F_0F0F);

    for (int chunk = 0; chunk < 12; chunk++) begin
      write_depth(5'(depth_plan[chunk]));
      idle_pct = (chunk < 4) ? 34 : ((chunk < 8) ? 85 : 0);
      add_random_ops(140, chunk == 11);
    end

    write_depth(5'd3);
    add_op(CMD_SEND, 32'hDEAD_BEEF);
    add_op(CMD_SEND, 32'h0000_0001);
    add_op(CMD_CLOSE, '0, 1'b1, 1'b0);
    add_op(CMD_SEND, 32'hFFFF_FFFF);
    add_op(CMD_PEEK);
    add_op(CMD_RECV);
    add_op(CMD_CLOSE, '0, 1'b1, 1'b0);
    write_depth(5'd2);
    add_op(CMD_SEND, 32'h1111_1111);
    add_op(CMD_PEEK);
    add_op(CMD_CLOSE, '0, 1'b0, 1'b1);
    add_op(CMD_PEEK);
    add_op(CMD_RECV);
    add_op(CMD_CLOSE, '0, 1'b1, 1'b1);
    add_op(CMD_SEND, 32'h2222_2222);

    wait_drained();
    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_closable_bounded_fifo passed");
    end else begin
      $display("tb_closable_bounded_fifo failed");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_closable_bounded_fifo failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/cbf_pkg.sv
rtl/core/cbf_ram.sv
rtl/core/cbf_ctrl.sv
rtl/core/closable_bounded_fifo.sv
tb/tb_closable_bounded_fifo.sv
